>>> sv/ufbs_pkg.sv
// ----------------------------------------------------------------------------
// ufbs_pkg: shared types and constants
// Widths, register indexes and the peripheral clock divide table for the
// fractional baud divider search.
// ----------------------------------------------------------------------------
`default_nettype none
package ufbs_pkg;

    localparam int CLK_W   = 27;
    localparam int BAUD_W  = 23;
    localparam int LATCH_W = 16;
    localparam int MUL_W   = 4;
    localparam int ERR_W   = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [0:0] REG_CORE_CLOCK = 1'b0;
    localparam logic [0:0] REG_PCLK_SEL   = 1'b1;

    localparam logic [CLK_W-1:0] CORE_CLOCK_RESET = 27'd100000000;
    localparam logic [MUL_W-1:0] MUL_MAX = 4'd15;
    localparam logic [ERR_W-1:0] ERR_NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [BAUD_W-1:0] baud;
        logic [CLK_W-1:0]  pclk;
    } job_t;

    function automatic logic [CLK_W-1:0] pclk_of(input logic [CLK_W-1:0] clk_hz,
                                                  input logic [1:0] sel);
        logic [CLK_W-1:0] r;
        begin
            unique case (sel)
                2'd0: r = clk_hz >> 2;
                2'd1: r = clk_hz;
                2'd2: r = clk_hz >> 1;
                default: r = clk_hz >> 3;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

>>> sv/ufbs_div.sv
// ----------------------------------------------------------------------------
// ufbs_div: serial restoring divider
// One quotient bit per cycle, 36-bit dividend over a 36-bit divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module ufbs_div #(
    parameter int W = 36
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         go,
    input  wire logic [W-1:0] num,
    input  wire logic [W-1:0] den,
    output logic              done,
    output logic [W-1:0]      quo
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[W-1]} - {1'b0, den_reg};
        if (go)
        begin
            rem_next = '0;
            quo_next = num;
            den_next = den;
            cnt_next = CW'(W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule
`default_nettype wire

>>> sv/ufbs_front.sv
// ----------------------------------------------------------------------------
// ufbs_front: request intake and job queue
// Holds the configuration, derives the peripheral clock and queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module ufbs_front #(
    parameter int DEPTH = ufbs_pkg::QUEUE_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [ufbs_pkg::BAUD_W-1:0]  baud_rate,
    output logic                              busy,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic                         cfg_index,
    input  wire logic [31:0]                  cfg_data,
    output logic                              job_valid,
    output ufbs_pkg::job_t                    job,
    input  wire logic                         job_take
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ufbs_pkg::CLK_W-1:0] clk_hz_reg;
    logic [1:0]                 sel_reg;
    ufbs_pkg::job_t             mem [DEPTH];
    logic [AW-1:0]              wr_reg, rd_reg;
    logic [AW:0]                cnt_reg;
    logic                       push;

    assign cfg_ready = 1'b1;
    assign busy      = (cnt_reg == (AW+1)'(DEPTH));
    assign push      = start && !busy;
    assign job_valid = (cnt_reg != '0);
    assign job       = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= ufbs_pkg::CORE_CLOCK_RESET;
            sel_reg    <= 2'd0;
            wr_reg     <= '0;
            rd_reg     <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == ufbs_pkg::REG_CORE_CLOCK)
                    clk_hz_reg <= cfg_data[ufbs_pkg::CLK_W-1:0];
                else
                    sel_reg <= cfg_data[1:0];
            end
            if (push)
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (job_take && job_valid)
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(job_take && job_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg].baud <= baud_rate;
            mem[wr_reg].pclk <= ufbs_pkg::pclk_of(clk_hz_reg, sel_reg);
        end
    end
endmodule
`default_nettype wire

>>> sv/ufbs_back.sv
// ----------------------------------------------------------------------------
// ufbs_back: candidate search sequencer
// Walks every multiplier and add value, computing the rounded latch and
// the achieved rate with one shared serial divider, and keeps the best.
// ----------------------------------------------------------------------------
`default_nettype none
module ufbs_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          job_valid,
    input  wire ufbs_pkg::job_t                job,
    output logic                               job_take,
    output logic                               done,
    output logic [ufbs_pkg::LATCH_W-1:0]       divisor,
    output logic [ufbs_pkg::MUL_W-1:0]         mul_val,
    output logic [ufbs_pkg::MUL_W-1:0]         div_add,
    output logic [ufbs_pkg::ERR_W-1:0]         rate_error,
    output logic                               found
);
    localparam int DW = 36;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_QDIV  = 6'b000010,
        S_QWAIT = 6'b000100,
        S_CAND  = 6'b001000,
        S_RWAIT = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    ufbs_pkg::job_t                job_reg;
    logic [ufbs_pkg::MUL_W-1:0]    mul_reg, add_reg;
    logic [DW-1:0]                 q_reg;
    logic [DW-1:0]                 bm_reg;   // baud * mul
    logic [ufbs_pkg::LATCH_W-1:0]  latch_reg;
    logic [ufbs_pkg::LATCH_W-1:0]  best_latch_reg;
    logic [ufbs_pkg::MUL_W-1:0]    best_mul_reg, best_add_reg;
    logic [ufbs_pkg::ERR_W-1:0]    best_err_reg;
    logic                          found_reg, done_reg;

    logic          dgo;
    logic [DW-1:0] dnum, dden, dquo;
    logic          ddone;
    logic [DW-1:0] lat_full;
    logic [DW-1:0] err_v;
    logic          last_add, last_mul;

    ufbs_div #(.W(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum), .den(dden),
        .done(ddone), .quo(dquo)
    );

    assign lat_full = q_reg - DW'(add_reg);
    assign err_v    = (dquo > DW'(job_reg.baud)) ? dquo - DW'(job_reg.baud)
                                                  : DW'(job_reg.baud) - dquo;
    assign last_add = (add_reg == mul_reg - 1'b1);
    assign last_mul = (mul_reg == ufbs_pkg::MUL_MAX);

    always_comb
    begin
        state_next = state_reg;
        dgo  = 1'b0;
        dnum = '0;
        dden = '0;
        unique case (state_reg)
            S_IDLE:
                if (job_valid)
                    state_next = (job.baud == '0) ? S_OUT : S_QDIV;
            S_QDIV:
            begin
                dgo  = 1'b1;
                dnum = DW'(job_reg.pclk) + {bm_reg[DW-4:0], 3'b0};
                dden = {bm_reg[DW-5:0], 4'b0};
                state_next = S_QWAIT;
            end
            S_QWAIT: if (ddone) state_next = S_CAND;
            S_CAND:
            begin
                if (q_reg > DW'(add_reg) && lat_full <= DW'(16'hFFFF))
                begin
                    dgo  = 1'b1;
                    dnum = DW'(job_reg.pclk) * DW'(mul_reg);
                    dden = (DW'(lat_full[15:0]) * DW'(mul_reg) + DW'(add_reg)) << 4;
                    state_next = S_RWAIT;
                end
                else if (last_add)
                    state_next = last_mul ? S_OUT : S_QDIV;
            end
            S_RWAIT:
                if (ddone)
                    state_next = last_add ? (last_mul ? S_OUT : S_QDIV) : S_CAND;
            default: state_next = S_IDLE;
        endcase
    end

    assign job_take = (state_reg == S_IDLE) && job_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_OUT);
            if (state_reg == S_IDLE && job_valid)
                found_reg <= 1'b0;
            if (state_reg == S_RWAIT && ddone &&
                (!found_reg || err_v < DW'(best_err_reg)))
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                job_reg        <= job;
                mul_reg        <= 4'd1;
                add_reg        <= '0;
                bm_reg         <= DW'(job.baud);
                best_latch_reg <= '0;
                best_mul_reg   <= 4'd1;
                best_add_reg   <= '0;
                best_err_reg   <= ufbs_pkg::ERR_NONE;
            end
            S_QWAIT:
                if (ddone)
                begin
                    q_reg   <= dquo;
                    add_reg <= '0;
                end
            S_CAND:
            begin
                latch_reg <= lat_full[15:0];
                if (!(q_reg > DW'(add_reg) && lat_full <= DW'(16'hFFFF)))
                begin
                    if (last_add)
                    begin
                        mul_reg <= mul_reg + 1'b1;
                        bm_reg  <= bm_reg + DW'(job_reg.baud);
                    end
                    else
                        add_reg <= add_reg + 1'b1;
                end
            end
            S_RWAIT:
                if (ddone)
                begin
                    if (!found_reg || err_v < DW'(best_err_reg))
                    begin
                        best_err_reg   <= err_v[ufbs_pkg::ERR_W-1:0];
                        best_latch_reg <= latch_reg;
                        best_mul_reg   <= mul_reg;
                        best_add_reg   <= add_reg;
                    end
                    if (last_add)
                    begin
                        mul_reg <= mul_reg + 1'b1;
                        bm_reg  <= bm_reg + DW'(job_reg.baud);
                    end
                    else
                        add_reg <= add_reg + 1'b1;
                end
            default: ;
        endcase
    end

    assign done       = done_reg;
    assign divisor    = best_latch_reg;
    assign mul_val    = best_mul_reg;
    assign div_add    = best_add_reg;
    assign rate_error = best_err_reg;
    assign found      = found_reg;
endmodule
`default_nettype wire

>>> sv/uart_fractional_baud_search_unit.sv
// ----------------------------------------------------------------------------
// uart_fractional_baud_search_unit: fractional baud divider search
//
// channel   signals                                         direction
// request   start, busy, baud_rate                          in
// result    done, divisor, mul_val, div_add, rate_error,    out
//           found
// config    cfg_valid, cfg_ready, cfg_index, cfg_data       in
//
// A search runs 15 rounding divisions and up to 120 rate divisions on
// the one shared serial divider, each one started, then 36 quotient bits,
// then collected; a skipped candidate needs no division, and a zero rate
// skips the search and goes straight to the result.
// A two-word queue takes requests while a search runs; busy is high only
// when it is full. Reset clears all control state. The result is shown for
// one cycle with done; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none
module uart_fractional_baud_search_unit #(
    parameter int QUEUE_DEPTH = ufbs_pkg::QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ufbs_pkg::BAUD_W-1:0]   baud_rate,
    output logic                               done,
    output logic [ufbs_pkg::LATCH_W-1:0]       divisor,
    output logic [ufbs_pkg::MUL_W-1:0]         mul_val,
    output logic [ufbs_pkg::MUL_W-1:0]         div_add,
    output logic [ufbs_pkg::ERR_W-1:0]         rate_error,
    output logic                               found,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [31:0]                   cfg_data
);
    logic           job_valid, job_take;
    ufbs_pkg::job_t job;

    ufbs_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .baud_rate(baud_rate),
        .busy(busy), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .job_valid(job_valid), .job(job), .job_take(job_take)
    );

    ufbs_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
        .job_take(job_take), .done(done), .divisor(divisor),
        .mul_val(mul_val), .div_add(div_add), .rate_error(rate_error),
        .found(found)
    );
endmodule
`default_nettype wire
